// File: sv/sle_pkg.sv
`default_nettype none

package sle_pkg;

  // terminal characters
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_CSI  = 8'h5b;
  localparam logic [7:0] CH_UP   = 8'h41;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_GT   = 8'h3e;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_L    = 8'h6c;
  localparam logic [7:0] CH_M    = 8'h6d;
  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_FOUR = 8'h34;

  // escape tracking
  typedef logic [1:0] phase_t;
  localparam phase_t PH_NONE = 2'd0;
  localparam phase_t PH_ESC  = 2'd1;
  localparam phase_t PH_CSI  = 2'd2;

  // source of an outgoing word
  typedef logic [1:0] src_t;
  localparam src_t SRC_BYTE   = 2'd0;
  localparam src_t SRC_BS     = 2'd1;
  localparam src_t SRC_HIST   = 2'd2;
  localparam src_t SRC_PROMPT = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic   load_byte;
    logic   set_phase;
    phase_t phase_val;
    logic   emit;
    src_t   src;
    logic   emit_last;
    logic   echo_upd;
    logic   save_step;
    logic   run_cmd;
    logic   len_from_hist;
    logic   idx_clr;
    logic   idx_inc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic   out_free;
    phase_t phase;
    logic   byte_esc;
    logic   byte_csi;
    logic   byte_up;
    logic   line_empty;
    logic   hist_empty;
    logic   line_end;
    logic   save_needed;
    logic   idx_last_line;
    logic   idx_last_hist;
    logic   idx_last_prompt;
  } stat_t;

  // prompt sequence: LF CR '>' space
  function automatic logic [7:0] prompt_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = CH_LF;
      2'd1:    b = CH_CR;
      2'd2:    b = CH_GT;
      default: b = CH_SP;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: sv/sle_ctrl.sv
`default_nettype none

module sle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sle_pkg::stat_t stat,
  output sle_pkg::cmd_t      cmd
);
  import sle_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_ECHO   = 4'd2;
  localparam logic [3:0] S_SAVE   = 4'd3;
  localparam logic [3:0] S_CMD    = 4'd4;
  localparam logic [3:0] S_PROMPT = 4'd5;
  localparam logic [3:0] S_BS     = 4'd6;
  localparam logic [3:0] S_RPRIME = 4'd7;
  localparam logic [3:0] S_RECALL = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencing of one received byte
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        cmd.set_phase = 1'b1;
        if (stat.byte_esc) begin
          cmd.phase_val = PH_ESC;
          state_nxt     = S_IDLE;
        end else if (stat.phase == PH_ESC && stat.byte_csi) begin
          cmd.phase_val = PH_CSI;
          state_nxt     = S_IDLE;
        end else if (stat.phase == PH_CSI) begin
          cmd.phase_val = PH_NONE;
          cmd.idx_clr   = 1'b1;
          if (!stat.byte_up) begin
            state_nxt = S_IDLE;
          end else if (!stat.line_empty) begin
            state_nxt = S_BS;
          end else if (!stat.hist_empty) begin
            state_nxt = S_RPRIME;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.phase_val = PH_NONE;
          state_nxt     = S_ECHO;
        end
      end
      S_ECHO: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_BYTE;
          cmd.emit_last = !stat.line_end;
          cmd.echo_upd  = 1'b1;
          cmd.idx_clr   = 1'b1;
          if (!stat.line_end) begin
            state_nxt = S_IDLE;
          end else if (stat.save_needed) begin
            state_nxt = S_SAVE;
          end else begin
            state_nxt = S_CMD;
          end
        end
      end
      // copy the finished line into history, one entry a cycle
      S_SAVE: begin
        cmd.save_step = 1'b1;
        cmd.idx_inc   = 1'b1;
        if (stat.idx_last_hist) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        cmd.run_cmd = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt   = S_PROMPT;
      end
      S_PROMPT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_PROMPT;
          cmd.emit_last = stat.idx_last_prompt;
          cmd.idx_inc   = 1'b1;
          if (stat.idx_last_prompt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      // rub out the current line on the terminal
      S_BS: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_BS;
          cmd.emit_last = stat.idx_last_line && stat.hist_empty;
          cmd.idx_inc   = 1'b1;
          if (stat.idx_last_line) begin
            cmd.idx_clr = 1'b1;
            if (stat.hist_empty) begin
              cmd.len_from_hist = 1'b1;
              state_nxt         = S_IDLE;
            end else begin
              state_nxt = S_RPRIME;
            end
          end
        end
      end
      // first history read is in flight
      S_RPRIME: begin
        state_nxt = S_RECALL;
      end
      S_RECALL: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_HIST;
          cmd.emit_last = stat.idx_last_hist;
          cmd.idx_inc   = 1'b1;
          if (stat.idx_last_hist) begin
            cmd.len_from_hist = 1'b1;
            state_nxt         = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/sle_dp.sv
`default_nettype none

module sle_dp #(
  parameter int LINE_LEN = 20
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    in_rx_byte,
  input  wire sle_pkg::cmd_t cmd,
  output sle_pkg::stat_t     stat,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [7:0]         out_tx_byte,
  output logic [3:0]         out_led_bits,
  output logic               out_last
);
  import sle_pkg::*;

  localparam int IW = $clog2(LINE_LEN);
  localparam logic [IW-1:0] LEN_FULL = IW'(LINE_LEN - 1);
  localparam logic [IW-1:0] SEL_POS  = IW'(4);
  localparam logic [IW-1:0] ONE      = IW'(1);
  localparam logic [IW-1:0] PR_LAST  = IW'(3);

  logic [7:0]    byte_r;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    line_r [LINE_LEN];
  logic [7:0]    hist_mem [LINE_LEN];
  logic [7:0]    hist_q_r;
  logic [IW-1:0] len_r, len_nxt;
  logic [IW-1:0] hist_len_r, hist_len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [3:0]    led_r, led_nxt;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic [3:0]    out_led_r;
  logic          out_last_r;

  logic          is_bs, len_nz, is_rub;
  logic [IW-1:0] echo_len;
  logic          line_end;
  logic [7:0]    first_ch, sel_ch, sel_off;
  logic [3:0]    tog;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [IW-1:0] rd_addr;
  logic [7:0]    emit_byte;
  logic          hist_emit;

  // echo decode: backspace on a non-empty line shortens it, else the byte is stored
  assign is_bs    = (byte_r == CH_BS);
  assign len_nz   = (len_r != '0);
  assign is_rub   = is_bs && len_nz;
  assign echo_len = is_rub ? len_r - ONE : len_r + ONE;
  assign line_end = (byte_r == CH_CR) || (byte_r == CH_LF) || (echo_len >= LEN_FULL);
  assign hist_emit = cmd.emit && (cmd.src == SRC_HIST);

  // status towards the controller
  always_comb begin
    stat                 = '0;
    stat.out_free        = !out_valid_r || out_ready;
    stat.phase           = phase_r;
    stat.byte_esc        = (byte_r == CH_ESC);
    stat.byte_csi        = (byte_r == CH_CSI);
    stat.byte_up         = (byte_r == CH_UP);
    stat.line_empty      = !len_nz;
    stat.hist_empty      = (hist_len_r == '0);
    stat.line_end        = line_end;
    stat.save_needed     = (echo_len > ONE);
    stat.idx_last_line   = (idx_r == len_r - ONE);
    stat.idx_last_hist   = (idx_r == hist_len_r - ONE);
    stat.idx_last_prompt = (idx_r == PR_LAST);
  end

  // command decode, seen with the end-of-line zero already in place
  always_comb begin
    first_ch = (len_r == '0) ? 8'h00 : line_r[0];
    sel_ch   = (len_r == SEL_POS) ? 8'h00 : line_r[4];
    sel_off  = sel_ch - CH_ONE;
    tog      = 4'b0000;
    if (first_ch == CH_L) begin
      if (sel_ch >= CH_ONE && sel_ch <= CH_FOUR) begin
        tog = 4'b0001 << sel_off[1:0];
      end else begin
        tog = 4'b0001;
      end
    end else if (first_ch == CH_M) begin
      tog = 4'b1000;
    end
  end

  // line store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = len_r;
    wr_data = byte_r;
    if (cmd.echo_upd && !is_rub) begin
      wr_en = 1'b1;
    end else if (cmd.run_cmd) begin
      wr_en   = 1'b1;
      wr_data = 8'h00;
    end else if (hist_emit) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = hist_q_r;
    end
  end

  // history read runs one entry ahead while replaying
  assign rd_addr = hist_emit ? idx_r + ONE : idx_r;

  // next values of the scalar state
  always_comb begin
    phase_nxt    = cmd.set_phase ? cmd.phase_val : phase_r;
    len_nxt      = len_r;
    hist_len_nxt = hist_len_r;
    led_nxt      = led_r;
    idx_nxt      = idx_r;
    if (cmd.echo_upd) begin
      len_nxt = echo_len;
      if (line_end && echo_len > ONE) begin
        hist_len_nxt = echo_len - ONE;
      end
    end
    if (cmd.run_cmd) begin
      len_nxt = '0;
      led_nxt = led_r ^ tog;
    end
    if (cmd.len_from_hist) begin
      len_nxt = hist_len_r;
    end
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ONE;
    end
  end

  // outgoing word
  always_comb begin
    case (cmd.src)
      SRC_BYTE:   emit_byte = byte_r;
      SRC_BS:     emit_byte = CH_BS;
      SRC_HIST:   emit_byte = hist_q_r;
      SRC_PROMPT: emit_byte = prompt_byte(idx_r[1:0]);
      default:    emit_byte = byte_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NONE;
      len_r       <= '0;
      hist_len_r  <= '0;
      led_r       <= 4'b0000;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      hist_len_r <= hist_len_nxt;
      led_r      <= led_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line store, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_LEN; i++) begin
        line_r[i] <= 8'h00;
      end
    end else if (wr_en) begin
      line_r[wr_addr] <= wr_data;
    end
  end

  // history memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.save_step) begin
      hist_mem[idx_r] <= line_r[idx_r];
    end
    hist_q_r <= hist_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_byte) begin
      byte_r <= in_rx_byte;
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_led_r  <= led_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tx_byte  = out_byte_r;
  assign out_led_bits = out_led_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// File: sv/serial_line_editor_with_recall.sv
`default_nettype none

// Terminal line editor with one line of recall. Each received byte gives zero or more
// words on the result side, the final one flagged by out_last. A plain byte is taken
// in the idle state, dispatched, and echoed from the echo state into the output
// register, waiting while that register is still occupied. Ending a line copies
// the line less its last byte into history when that leaves at least one byte
// (through the single write port of the history memory), runs the command and
// sends four prompt words. ESC [ A sends one backspace word per character of the
// line, primes the history read, then replays the stored characters. ESC and
// ESC [ give no words. A new byte is taken only once the
// previous one has issued all its words; the last word may still wait in the output
// register. LEDs change only when a line is ended, and each word carries the LED
// state at the time it was sent.
module serial_line_editor_with_recall #(
  parameter int LINE_LEN = 20
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_tx_byte,
  output logic [3:0]      out_led_bits,
  output logic            out_last
);
  import sle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sle_dp #(
    .LINE_LEN (LINE_LEN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_rx_byte   (in_rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_tx_byte  (out_tx_byte),
    .out_led_bits (out_led_bits),
    .out_last     (out_last)
  );

`ifndef SYNTHESIS
  // a word is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("word issued while output register occupied");

  // the final word of a byte returns the controller to idle
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_last) |=> in_ready)
    else $error("input not ready after final word");

  // an escape byte is absorbed through the dispatch state back to idle
  a_esc_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_rx_byte == CH_ESC) |-> ##2 in_ready)
    else $error("escape byte not absorbed in time");
`endif

endmodule

`default_nettype wire
